// ----- sv/bep_pkg.sv -----
`timescale 1ns / 1ps
// bep_pkg: constants, register codes, stage structs and helpers of the erosion pass
// depends on nothing; used by the interfaces and every module of the block but bep_ram
package bep_pkg;

    // frame and window limits
    localparam int MAX_WIDTH    = 1024;
    localparam int MAX_RADIUS   = 7;
    localparam int HEIGHT_LIMIT = 4096;

    // field widths
    localparam int PIX_W     = 8;
    localparam int RAD_W     = 3;
    localparam int FWIDTH_W  = 11;
    localparam int FHEIGHT_W = 13;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int ROW_W     = 12;
    localparam int CLR_W     = COL_W + 1;

    // saturating run counters
    localparam int RUN_CAP = 2 * MAX_RADIUS + 1;
    localparam int RUN_W   = $clog2(RUN_CAP + 1);

    localparam logic [PIX_W-1:0] GRAY_MAX = PIX_W'(255);

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WINDOW_RADIUS    = 2'd0,
        REG_FOREGROUND_VALUE = 2'd1,
        REG_FRAME_WIDTH      = 2'd2,
        REG_FRAME_HEIGHT     = 2'd3
    } bep_reg_idx_t;

    // effective (clamped) configuration
    typedef struct packed {
        logic [RAD_W-1:0]     radius;
        logic [RUN_W-1:0]     need;
        logic [RUN_W-1:0]     diam;
        logic [PIX_W-1:0]     fg;
        logic [FWIDTH_W-1:0]  width;
        logic [FHEIGHT_W-1:0] height;
    } bep_cfg_t;

    // item as it leaves the position stage
    typedef struct packed {
        logic [PIX_W-1:0] pixel_value;
        logic [COL_W-1:0] col;
        logic             col_zero;
        logic             row_zero;
        logic             emit;
        logic             last;
        logic [COL_W-1:0] out_column;
        logic [ROW_W-1:0] out_row;
    } bep_s0_t;

    // run memory write request
    typedef struct packed {
        logic             en;
        logic [COL_W-1:0] addr;
        logic [RUN_W-1:0] data;
    } bep_wr_t;

    function automatic logic [RUN_W-1:0] inc_sat(input logic [RUN_W-1:0] v);
        logic [RUN_W-1:0] r;
        if (v >= RUN_W'(RUN_CAP))
            r = RUN_W'(RUN_CAP);
        else
            r = v + RUN_W'(1);
        return r;
    endfunction

endpackage

// ----- sv/bep_if.sv -----
`timescale 1ns / 1ps
// bep_if: valid/ready channel interfaces for pixels, results and register writes
// depends on bep_pkg for field widths
interface bep_pix_if;
    logic                      valid;
    logic                      ready;
    logic [bep_pkg::PIX_W-1:0] pixel_value;

    modport source (output valid, output pixel_value, input ready);
    modport sink   (input valid, input pixel_value, output ready);
endinterface

interface bep_res_if;
    logic                      valid;
    logic                      ready;
    logic [bep_pkg::COL_W-1:0] out_column;
    logic [bep_pkg::ROW_W-1:0] out_row;
    logic [bep_pkg::PIX_W-1:0] out_value;
    logic                      frame_end;
    logic                      any_kept;

    modport source (output valid, output out_column, output out_row, output out_value,
                    output frame_end, output any_kept, input ready);
    modport sink   (input valid, input out_column, input out_row, input out_value,
                    input frame_end, input any_kept, output ready);
endinterface

interface bep_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [bep_pkg::CFG_IDX_W-1:0]  index;
    logic [bep_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- sv/bep_ram.sv -----
`timescale 1ns / 1ps
// bep_ram: generic single-write, single-read memory with registered read data
// depends on nothing
module bep_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata <= mem[raddr];
    end

endmodule

// ----- sv/bep_cfg_regs.sv -----
`timescale 1ns / 1ps
// bep_cfg_regs: configuration registers and their clamped working values
// depends on bep_pkg and bep_cfg_if
module bep_cfg_regs (
    input  logic              clk,
    input  logic              rst_n,
    bep_cfg_if.sink           cfg,
    output bep_pkg::bep_cfg_t cfg_eff
);

    logic [bep_pkg::RAD_W-1:0]     radius_reg;
    logic [bep_pkg::PIX_W-1:0]     fg_reg;
    logic [bep_pkg::FWIDTH_W-1:0]  width_reg;
    logic [bep_pkg::FHEIGHT_W-1:0] height_reg;
    logic [bep_pkg::RAD_W-1:0]     radius_c;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= bep_pkg::RAD_W'(1);
            fg_reg     <= bep_pkg::PIX_W'(255);
            width_reg  <= bep_pkg::FWIDTH_W'(640);
            height_reg <= bep_pkg::FHEIGHT_W'(480);
        end
        else if (cfg.valid)
        begin
            unique case (bep_pkg::bep_reg_idx_t'(cfg.index))
                bep_pkg::REG_WINDOW_RADIUS:
                    radius_reg <= cfg.data[bep_pkg::RAD_W-1:0];
                bep_pkg::REG_FOREGROUND_VALUE:
                    fg_reg <= cfg.data[bep_pkg::PIX_W-1:0];
                bep_pkg::REG_FRAME_WIDTH:
                    width_reg <= cfg.data[bep_pkg::FWIDTH_W-1:0];
                bep_pkg::REG_FRAME_HEIGHT:
                    height_reg <= cfg.data[bep_pkg::FHEIGHT_W-1:0];
                default:
                    ;
            endcase
        end
    end

    always_comb
    begin
        if (radius_reg > bep_pkg::RAD_W'(bep_pkg::MAX_RADIUS))
            radius_c = bep_pkg::RAD_W'(bep_pkg::MAX_RADIUS);
        else
            radius_c = radius_reg;

        cfg_eff.radius = radius_c;
        cfg_eff.diam   = bep_pkg::RUN_W'({radius_c, 1'b0});
        cfg_eff.need   = bep_pkg::RUN_W'({radius_c, 1'b1});
        cfg_eff.fg     = fg_reg;

        // zero counts as one, oversize counts as the limit
        if (width_reg == '0)
            cfg_eff.width = bep_pkg::FWIDTH_W'(1);
        else if (width_reg > bep_pkg::FWIDTH_W'(bep_pkg::MAX_WIDTH))
            cfg_eff.width = bep_pkg::FWIDTH_W'(bep_pkg::MAX_WIDTH);
        else
            cfg_eff.width = width_reg;

        if (height_reg == '0)
            cfg_eff.height = bep_pkg::FHEIGHT_W'(1);
        else if (height_reg > bep_pkg::FHEIGHT_W'(bep_pkg::HEIGHT_LIMIT))
            cfg_eff.height = bep_pkg::FHEIGHT_W'(bep_pkg::HEIGHT_LIMIT);
        else
            cfg_eff.height = height_reg;
    end

endmodule

// ----- sv/bep_position.sv -----
`timescale 1ns / 1ps
// bep_position: raster position tracking, run memory read address and reset clear sweep
// depends on bep_pkg
module bep_position (
    input  logic                      clk,
    input  logic                      rst_n,
    input  bep_pkg::bep_cfg_t         cfg_eff,
    input  logic                      accept,
    input  logic [bep_pkg::PIX_W-1:0] pixel_value,
    output bep_pkg::bep_s0_t          s0,
    output logic [bep_pkg::COL_W-1:0] rd_addr,
    output logic                      clearing,
    output logic [bep_pkg::COL_W-1:0] clr_addr
);

    logic [bep_pkg::COL_W-1:0]     col_pos_reg, col_pos_next;
    logic [bep_pkg::ROW_W-1:0]     row_pos_reg, row_pos_next;
    logic [bep_pkg::CLR_W-1:0]     clr_cnt_reg, clr_cnt_next;
    logic                          c_wrap;
    logic [bep_pkg::FHEIGHT_W-1:0] row_t;
    logic [bep_pkg::COL_W-1:0]     col_cur;
    logic [bep_pkg::ROW_W-1:0]     row_cur;
    logic [bep_pkg::FWIDTH_W-1:0]  col_inc;
    logic [bep_pkg::FHEIGHT_W-1:0] row_inc;

    always_comb
    begin
        // positions left over from a larger frame wrap first
        c_wrap  = bep_pkg::FWIDTH_W'(col_pos_reg) >= cfg_eff.width;
        row_t   = bep_pkg::FHEIGHT_W'(row_pos_reg) + bep_pkg::FHEIGHT_W'(c_wrap);
        col_cur = c_wrap ? '0 : col_pos_reg;
        row_cur = (row_t >= cfg_eff.height) ? '0 : row_t[bep_pkg::ROW_W-1:0];

        col_inc = bep_pkg::FWIDTH_W'(col_cur) + bep_pkg::FWIDTH_W'(1);
        row_inc = bep_pkg::FHEIGHT_W'(row_cur) + bep_pkg::FHEIGHT_W'(1);
        if (col_inc >= cfg_eff.width)
        begin
            col_pos_next = '0;
            row_pos_next = (row_inc >= cfg_eff.height) ? '0 : row_inc[bep_pkg::ROW_W-1:0];
        end
        else
        begin
            col_pos_next = col_inc[bep_pkg::COL_W-1:0];
            row_pos_next = row_cur;
        end

        s0.pixel_value = pixel_value;
        s0.col         = col_cur;
        s0.col_zero    = col_cur == '0;
        s0.row_zero    = row_cur == '0;
        s0.emit        = (col_cur >= bep_pkg::COL_W'(cfg_eff.diam))
                      && (row_cur >= bep_pkg::ROW_W'(cfg_eff.diam));
        s0.last        = (bep_pkg::FWIDTH_W'(col_cur) == cfg_eff.width - bep_pkg::FWIDTH_W'(1))
                      && (bep_pkg::FHEIGHT_W'(row_cur)
                          == cfg_eff.height - bep_pkg::FHEIGHT_W'(1));
        s0.out_column  = col_cur - bep_pkg::COL_W'(cfg_eff.radius);
        s0.out_row     = row_cur - bep_pkg::ROW_W'(cfg_eff.radius);

        rd_addr = col_cur;

        // zero-fill sweep of the run memory after reset
        clearing     = clr_cnt_reg != bep_pkg::CLR_W'(bep_pkg::MAX_WIDTH);
        clr_addr     = clr_cnt_reg[bep_pkg::COL_W-1:0];
        clr_cnt_next = clearing ? clr_cnt_reg + bep_pkg::CLR_W'(1) : clr_cnt_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_pos_reg <= '0;
            row_pos_reg <= '0;
            clr_cnt_reg <= '0;
        end
        else
        begin
            clr_cnt_reg <= clr_cnt_next;
            if (accept)
            begin
                col_pos_reg <= col_pos_next;
                row_pos_reg <= row_pos_next;
            end
        end
    end

endmodule

// ----- sv/bep_run_update.sv -----
`timescale 1ns / 1ps
// bep_run_update: run count read-modify-write with forwarding, window decision, result register
// depends on bep_pkg and bep_res_if
module bep_run_update (
    input  logic                      clk,
    input  logic                      rst_n,
    input  bep_pkg::bep_cfg_t         cfg_eff,
    input  logic                      load,
    input  bep_pkg::bep_s0_t          s0,
    input  logic [bep_pkg::RUN_W-1:0] rd_data,
    output logic                      s1_free,
    output bep_pkg::bep_wr_t          wr,
    bep_res_if.source                 res
);

    logic                      s1_valid_reg;
    bep_pkg::bep_s0_t          s1_reg;
    logic                      lw_valid_reg;
    logic [bep_pkg::COL_W-1:0] lw_addr_reg;
    logic [bep_pkg::RUN_W-1:0] lw_data_reg;
    logic [bep_pkg::RUN_W-1:0] row_run_reg, row_run_next;
    logic                      kept_reg, kept_next;
    logic                      out_valid_reg, out_valid_next;
    logic [bep_pkg::COL_W-1:0] out_column_reg;
    logic [bep_pkg::ROW_W-1:0] out_row_reg;
    logic [bep_pkg::PIX_W-1:0] out_value_reg;
    logic                      frame_end_reg;
    logic                      any_kept_reg;

    logic                      fire;
    logic                      fwd_hit;
    logic [bep_pkg::RUN_W-1:0] prev;
    logic [bep_pkg::RUN_W-1:0] run;
    logic [bep_pkg::RUN_W-1:0] rr_base;
    logic                      keep;
    logic                      kept_base;

    always_comb
    begin
        // newest write wins over a read that raced it
        fwd_hit = lw_valid_reg && (lw_addr_reg == s1_reg.col);
        if (s1_reg.row_zero)
            prev = '0;
        else if (fwd_hit)
            prev = lw_data_reg;
        else
            prev = rd_data;

        run = (s1_reg.pixel_value == cfg_eff.fg) ? bep_pkg::inc_sat(prev) : '0;

        rr_base      = s1_reg.col_zero ? '0 : row_run_reg;
        row_run_next = (run >= cfg_eff.need) ? bep_pkg::inc_sat(rr_base) : '0;
        keep         = row_run_next >= cfg_eff.need;

        kept_base = (s1_reg.col_zero && s1_reg.row_zero) ? 1'b0 : kept_reg;
        kept_next = kept_base | (s1_reg.emit & keep);

        fire    = s1_valid_reg && (!s1_reg.emit || !out_valid_reg || res.ready);
        s1_free = !s1_valid_reg || fire;

        wr.en   = fire;
        wr.addr = s1_reg.col;
        wr.data = run;

        out_valid_next = (fire && s1_reg.emit) || (out_valid_reg && !res.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            lw_valid_reg  <= 1'b0;
            row_run_reg   <= '0;
            kept_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= load || (s1_valid_reg && !fire);
            out_valid_reg <= out_valid_next;
            if (fire)
            begin
                lw_valid_reg <= 1'b1;
                row_run_reg  <= row_run_next;
                kept_reg     <= kept_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            s1_reg <= s0;
        if (fire)
        begin
            lw_addr_reg <= s1_reg.col;
            lw_data_reg <= run;
        end
        if (fire && s1_reg.emit)
        begin
            out_column_reg <= s1_reg.out_column;
            out_row_reg    <= s1_reg.out_row;
            out_value_reg  <= keep ? cfg_eff.fg : bep_pkg::GRAY_MAX - cfg_eff.fg;
            frame_end_reg  <= s1_reg.last;
            any_kept_reg   <= s1_reg.last && kept_next;
        end
    end

    assign res.valid      = out_valid_reg;
    assign res.out_column = out_column_reg;
    assign res.out_row    = out_row_reg;
    assign res.out_value  = out_value_reg;
    assign res.frame_end  = frame_end_reg;
    assign res.any_kept   = any_kept_reg;

endmodule

// ----- sv/binary_erosion_pass.sv -----
`timescale 1ns / 1ps
// binary_erosion_pass: top level of one binary erosion pass over a raster pixel stream
// depends on bep_pkg, bep_if, bep_ram, bep_cfg_regs, bep_position, bep_run_update
//
// channel  dir  payload                                             item accepted when
// -------  ---  --------------------------------------------------  -------------------------
// pix_in   in   pixel_value[7:0]                                    pix_in.valid & pix_in.ready
// res_out  out  out_column[9:0] out_row[11:0] out_value[7:0]        res_out.valid & res_out.ready
//               frame_end any_kept
// cfg      in   index[1:0] data[12:0]                               cfg.valid & cfg.ready
//
// one pixel per cycle sustained once the clear sweep is done and while no result stalls;
// the run memory sees at most one read and one write each cycle; an interior pixel is taken
// into the update stage register and its result goes on into the output register, unless
// the output register still holds an unaccepted result; after reset all 1024 run memory
// entries are zero-filled with pix_in.ready low; register writes are taken during that sweep
// a stalled result holds the pipe only when the next item also produces a result
module binary_erosion_pass (
    input  logic       clk,
    input  logic       rst_n,
    bep_pix_if.sink    pix_in,
    bep_res_if.source  res_out,
    bep_cfg_if.sink    cfg
);

    bep_pkg::bep_cfg_t         cfg_eff;
    bep_pkg::bep_s0_t          s0;
    bep_pkg::bep_wr_t          wr;
    logic [bep_pkg::COL_W-1:0] rd_addr;
    logic [bep_pkg::COL_W-1:0] clr_addr;
    logic                      clearing;
    logic                      s1_free;
    logic                      accept;
    logic [bep_pkg::RUN_W-1:0] rd_data;

    // memory write port: clear sweep or run write-back
    logic                      mem_we;
    logic [bep_pkg::COL_W-1:0] mem_waddr;
    logic [bep_pkg::RUN_W-1:0] mem_wdata;

    // register file with clamping of width, height and radius
    bep_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .cfg_eff (cfg_eff)
    );

    // take a pixel when the clear sweep is done and the update stage can move
    assign pix_in.ready = !clearing && s1_free;
    assign accept       = pix_in.valid && pix_in.ready;

    // first stage: column and row of the pixel, memory read issued at the accept edge
    bep_position u_position (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_eff     (cfg_eff),
        .accept      (accept),
        .pixel_value (pix_in.pixel_value),
        .s0          (s0),
        .rd_addr     (rd_addr),
        .clearing    (clearing),
        .clr_addr    (clr_addr)
    );

    always_comb
    begin
        mem_we    = clearing || wr.en;
        mem_waddr = clearing ? clr_addr : wr.addr;
        mem_wdata = clearing ? '0 : wr.data;
    end

    // vertical run count per column
    bep_ram #(
        .WIDTH (bep_pkg::RUN_W),
        .DEPTH (bep_pkg::MAX_WIDTH)
    ) u_col_runs (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // second stage: run update, horizontal run, keep decision, output register
    bep_run_update u_run_update (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg_eff (cfg_eff),
        .load    (accept),
        .s0      (s0),
        .rd_data (rd_data),
        .s1_free (s1_free),
        .wr      (wr),
        .res     (res_out)
    );

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// tb: self-checking bench for binary_erosion_pass, with directed frames, random frames and backpressure
// depends on bep_pkg, bep_if and the binary_erosion_pass rtl
module tb;
    import bep_pkg::*;

    localparam int CLK_PERIOD    = 8;
    localparam int RESET_CYCLES  = 8;
    localparam int SETTLE_CYCLES = 8;
    localparam int RUN_LIMIT     = 1000000;

    // one emitted interior pixel as the block should report it
    typedef struct packed {
        logic [COL_W-1:0] column;
        logic [ROW_W-1:0] row;
        logic [PIX_W-1:0] value;
        logic             frame_end;
        logic             any_kept;
    } erosion_result_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    bep_pix_if pix_ch ();
    bep_res_if res_ch ();
    bep_cfg_if cfg_ch ();

    binary_erosion_pass u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .pix_in  (pix_ch),
        .res_out (res_ch),
        .cfg     (cfg_ch)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // pacing knobs, percent of cycles
    int idle_pct    = 0;
    int stall_pct   = 0;
    int hold_left   = 0;
    int fail_count  = 0;
    int cycle_count = 0;

    // shadow of the block: registers as written, run counters, raster position
    logic [RAD_W-1:0]     cfg_radius;
    logic [PIX_W-1:0]     cfg_fg;
    logic [FWIDTH_W-1:0]  cfg_width;
    logic [FHEIGHT_W-1:0] cfg_height;
    logic [RUN_W-1:0]     col_runs [MAX_WIDTH];
    int unsigned          row_run;
    int unsigned          pos_col;
    int unsigned          pos_row;
    bit                   frame_kept;

    erosion_result_t erosion_expected [$];

    // saturating run increment
    function automatic int unsigned run_bump(input int unsigned v);
        return (v >= RUN_CAP) ? RUN_CAP : v + 1;
    endfunction

    // advance the shadow by one accepted pixel, queue the interior result if any
    task automatic predict_pixel(input logic [PIX_W-1:0] pixel);
        int unsigned w, h, r, need, col, row, prev, run;
        bit keep, last;
        erosion_result_t exp_res;
        w    = (cfg_width == 0) ? 1 : ((cfg_width > MAX_WIDTH) ? MAX_WIDTH : cfg_width);
        h    = (cfg_height == 0) ? 1 : ((cfg_height > HEIGHT_LIMIT) ? HEIGHT_LIMIT : cfg_height);
        r    = cfg_radius;
        need = 2 * r + 1;
        // a shrunk frame wraps the position before use
        if (pos_col >= w)
        begin
            pos_col = 0;
            pos_row++;
        end
        if (pos_row >= h)
            pos_row = 0;
        col = pos_col;
        row = pos_row;
        if (row == 0 && col == 0)
            frame_kept = 1'b0;
        // vertical run restarts on the first row of each frame
        prev = (row == 0) ? 0 : col_runs[col];
        run  = (pixel == cfg_fg) ? run_bump(prev) : 0;
        col_runs[col] = RUN_W'(run);
        // horizontal run over columns whose vertical run covers the window
        if (col == 0)
            row_run = 0;
        row_run = (run >= need) ? run_bump(row_run) : 0;
        // window bottom-right reached: decide the centre pixel
        if (col >= 2 * r && row >= 2 * r)
        begin
            keep = (row_run >= need);
            last = (col == w - 1) && (row == h - 1);
            if (keep)
                frame_kept = 1'b1;
            exp_res.column    = COL_W'(col - r);
            exp_res.row       = ROW_W'(row - r);
            exp_res.value     = keep ? cfg_fg : GRAY_MAX - cfg_fg;
            exp_res.frame_end = last;
            exp_res.any_kept  = last && frame_kept;
            erosion_expected.push_back(exp_res);
        end
        pos_col = col + 1;
        if (pos_col >= w)
        begin
            pos_col = 0;
            pos_row = row + 1;
            if (pos_row >= h)
                pos_row = 0;
        end
    endtask

    // offer one pixel, idling first at random, and wait for its handshake
    task automatic send_pixel(input logic [PIX_W-1:0] pixel);
        @(negedge clk);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            pix_ch.valid <= 1'b0;
            @(negedge clk);
        end
        pix_ch.valid       <= 1'b1;
        pix_ch.pixel_value <= pixel;
        @(posedge clk);
        while (pix_ch.ready !== 1'b1)
            @(posedge clk);
        predict_pixel(pixel);
    endtask

    // pixels equal to the foreground value with the given odds, otherwise any gray level
    task automatic stream_pixels(input int count, input int fg_pct);
        int i;
        for (i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 99) < fg_pct)
                send_pixel(cfg_fg);
            else
                send_pixel(PIX_W'($urandom_range(0, 255)));
        end
    endtask

    // stop offering and let every expected result come out, then let the pipe settle
    task automatic wait_for_results();
        @(negedge clk);
        pix_ch.valid <= 1'b0;
        while (erosion_expected.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input bep_reg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        @(posedge clk);
        while (cfg_ch.ready !== 1'b1)
            @(posedge clk);
        case (idx)
            REG_WINDOW_RADIUS:    cfg_radius = data[RAD_W-1:0];
            REG_FOREGROUND_VALUE: cfg_fg     = data[PIX_W-1:0];
            REG_FRAME_WIDTH:      cfg_width  = data[FWIDTH_W-1:0];
            REG_FRAME_HEIGHT:     cfg_height = data[FHEIGHT_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic set_window_and_frame(input logic [CFG_DATA_W-1:0] radius,
                                        input logic [CFG_DATA_W-1:0] fg,
                                        input logic [CFG_DATA_W-1:0] width,
                                        input logic [CFG_DATA_W-1:0] height);
        write_reg(REG_WINDOW_RADIUS, radius);
        write_reg(REG_FOREGROUND_VALUE, fg);
        write_reg(REG_FRAME_WIDTH, width);
        write_reg(REG_FRAME_HEIGHT, height);
    endtask

    task automatic set_pacing(input int idle, input int stall);
        idle_pct  = idle;
        stall_pct = stall;
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            fail_count++;
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
        end
    endtask

    // reset values on part of the first row, then short frames with reset radius and gray
    task automatic test_default_config();
        stream_pixels(40, 97);
        wait_for_results();
        write_reg(REG_FRAME_WIDTH, 13'd8);
        write_reg(REG_FRAME_HEIGHT, 13'd5);
        stream_pixels(8 * 5 * 2, 97);
        wait_for_results();
    endtask

    // radius zero: every pixel is interior and judged on itself; gray extremes
    task automatic test_single_pixel_window();
        logic [PIX_W-1:0] pattern [12];
        int i;
        pattern = '{8'h00, 8'hFF, 8'h00, 8'h01, 8'h00, 8'h00,
                    8'hFE, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h80};
        set_window_and_frame(13'd0, 13'h000, 13'd4, 13'd3);
        for (i = 0; i < 12; i++)
            send_pixel(pattern[i]);
        wait_for_results();
    endtask

    // widest window, runs pushed past the saturation point in both directions
    task automatic test_saturated_runs();
        set_window_and_frame(13'd7, 13'h0A5, 13'd17, 13'd16);
        stream_pixels(17 * 16, 100);
        wait_for_results();
    endtask

    // zero width and height act as one; a frame too small for the window emits nothing
    task automatic test_degenerate_sizes();
        set_window_and_frame(13'd0, 13'h055, 13'h0000, 13'h0000);
        stream_pixels(6, 50);
        wait_for_results();
        set_window_and_frame(13'd1, 13'h055, 13'd2, 13'd5);
        stream_pixels(10, 100);
        wait_for_results();
    endtask

    // upper data bits are dropped; a height beyond the limit counts as the tallest frame
    task automatic test_register_limits();
        set_window_and_frame(13'h1FF9, 13'h1E3C, 13'h1806, 13'h1FFF);
        stream_pixels(6 * 8, 95);
        wait_for_results();
    endtask

    // shrink width and height part way through a frame, position wraps
    task automatic test_midframe_resize();
        set_window_and_frame(13'd1, 13'h0FF, 13'd8, 13'd6);
        stream_pixels(21, 100);
        wait_for_results();
        write_reg(REG_FRAME_WIDTH, 13'd3);
        stream_pixels(10, 100);
        wait_for_results();
        write_reg(REG_FRAME_HEIGHT, 13'd2);
        stream_pixels(12, 100);
        wait_for_results();
    endtask

    // receiver holds off while pixels keep coming, so the block must stall its input
    task automatic test_output_backpressure();
        set_window_and_frame(13'd1, 13'h0FF, 13'd12, 13'd12);
        hold_left = 300;
        stream_pixels(12 * 12, 100);
        wait_for_results();
    endtask

    // random small frames, dense foreground mostly, under every pacing mode
    task automatic test_random_frames();
        int phase, sent, frame_px, fg_pct, radius;
        for (phase = 0; phase < 8; phase++)
        begin
            case (phase % 4)
                0:       set_pacing(0, 0);
                1:       set_pacing(58, 0);
                2:       set_pacing(0, 58);
                default: set_pacing(12, 12);
            endcase
            radius = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : $urandom_range(0, 2);
            write_reg(REG_WINDOW_RADIUS, {10'($urandom), 3'(radius)});
            write_reg(REG_FOREGROUND_VALUE, {5'($urandom), 8'($urandom)});
            write_reg(REG_FRAME_WIDTH, 13'($urandom_range(1, 14)));
            write_reg(REG_FRAME_HEIGHT, 13'($urandom_range(1, 10)));
            frame_px = cfg_width * cfg_height;
            sent = 0;
            while (sent < 50)
            begin
                case ($urandom_range(0, 3))
                    0:       fg_pct = 100;
                    1:       fg_pct = 97;
                    2:       fg_pct = 90;
                    default: fg_pct = 60;
                endcase
                stream_pixels(frame_px, fg_pct);
                sent += frame_px;
            end
            // sometimes leave a torn frame behind for the next setting
            if ($urandom_range(0, 3) == 0)
                stream_pixels($urandom_range(1, frame_px), 50);
            wait_for_results();
        end
        set_pacing(0, 0);
    endtask

    // result side: ready at the falling edge, random stalls or a long hold-off
    initial
    begin
        res_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else
                res_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // every accepted item on the result side against the oldest expectation
    always @(posedge clk)
    begin
        erosion_result_t want;
        if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
        begin
            if (erosion_expected.size() == 0)
            begin
                fail_count++;
                $display("%0t: result at column %0d row %0d with none expected",
                         $time, res_ch.out_column, res_ch.out_row);
            end
            else
            begin
                want = erosion_expected.pop_front();
                check_field("out_column", want.column, res_ch.out_column);
                check_field("out_row", want.row, res_ch.out_row);
                check_field("out_value", want.value, res_ch.out_value);
                check_field("frame_end", want.frame_end, res_ch.frame_end);
                check_field("any_kept", want.any_kept, res_ch.any_kept);
            end
        end
    end

    // watchdog
    initial
    begin
        while (cycle_count < RUN_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb failed");
        $finish;
    end

    initial
    begin
        int i;
        pix_ch.valid       = 1'b0;
        pix_ch.pixel_value = '0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = REG_WINDOW_RADIUS;
        cfg_ch.data        = '0;
        // shadow starts from the reset state of the block
        for (i = 0; i < MAX_WIDTH; i++)
            col_runs[i] = '0;
        row_run    = 0;
        pos_col    = 0;
        pos_row    = 0;
        frame_kept = 1'b0;
        cfg_radius = RAD_W'(1);
        cfg_fg     = PIX_W'(255);
        cfg_width  = FWIDTH_W'(640);
        cfg_height = FHEIGHT_W'(480);

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_default_config();
        test_single_pixel_window();
        test_saturated_runs();
        test_degenerate_sizes();
        test_register_limits();
        test_midframe_resize();
        test_output_backpressure();
        test_random_frames();

        // drain and give the pipe time to show any stray item
        wait_for_results();
        repeat (4 * SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && erosion_expected.size() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end
endmodule

// ----- sim.f -----
sv/bep_pkg.sv
sv/bep_if.sv
sv/bep_ram.sv
sv/bep_cfg_regs.sv
sv/bep_position.sv
sv/bep_run_update.sv
sv/binary_erosion_pass.sv
bench/tb.sv
